/* rtl/core/phrf_pkg.sv */
// Shared types, constants and the rule compare function of the packet header rule filter.
`timescale 1ns / 1ps

package phrf_pkg;

    // Table sizing
    localparam int MAX_RULES = 16;
    localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);

    // Request kinds
    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_MATCH = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_TESTS = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // Test flag bit positions
    localparam int T_NET   = 0;
    localparam int T_TRANS = 1;
    localparam int T_EPORT = 2;
    localparam int T_DPORT = 3;
    localparam int T_SPORT = 4;
    localparam int T_EADDR = 5;
    localparam int T_SADDR = 6;
    localparam int T_DADDR = 7;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // One stored rule
    typedef struct packed {
        logic [7:0]  tests;
        logic [15:0] net_proto;
        logic [7:0]  trans_proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] src_addr;
        logic [31:0] src_mask;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
    } rule_t;

    // Header under test
    typedef struct packed {
        logic [15:0] net_proto;
        logic [7:0]  trans_proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } hdr_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // request taken this cycle
        logic scan_en;    // step the rule scan
        logic scan_done;  // capture scan outcome as pending result
        logic out_load;   // move pending result into output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic start_scan; // incoming request needs a table scan
        logic scan_hit;   // rule in read stage matches
        logic scan_end;   // rule in read stage is the last one
    } stat_t;

    // All enabled tests of one rule against a header
    function automatic logic rule_hits(input rule_t r, input hdr_t h);
        logic [31:0] s_m;
        logic [31:0] d_m;
        logic [31:0] dd_m;
        logic        ok;
        s_m  = h.src_addr & r.src_mask;
        d_m  = h.dst_addr & r.src_mask;
        dd_m = h.dst_addr & r.dst_mask;
        ok   = 1'b1;
        if (r.tests[T_NET] && (r.net_proto != h.net_proto))
            ok = 1'b0;
        if (r.tests[T_TRANS] && (r.trans_proto != h.trans_proto))
            ok = 1'b0;
        if (r.tests[T_EPORT] && (r.src_port != h.src_port) && (r.src_port != h.dst_port))
            ok = 1'b0;
        if (r.tests[T_DPORT] && (r.dst_port != h.dst_port))
            ok = 1'b0;
        if (r.tests[T_SPORT] && (r.src_port != h.src_port))
            ok = 1'b0;
        if (r.tests[T_EADDR] && (r.src_addr != s_m) && (r.src_addr != d_m))
            ok = 1'b0;
        if (r.tests[T_SADDR] && (r.src_addr != s_m))
            ok = 1'b0;
        if (r.tests[T_DADDR] && (r.dst_addr != dd_m))
            ok = 1'b0;
        return ok;
    endfunction

endpackage

/* rtl/core/phrf_ctrl.sv */
// Controller state machine: request acceptance, scan sequencing, output register handshake.
`timescale 1ns / 1ps

module phrf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             res_valid,
    input  logic             res_stall,
    input  phrf_pkg::stat_t  stat,
    output phrf_pkg::cmd_t   cmd
);

    phrf_pkg::state_t state_reg;
    phrf_pkg::state_t state_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic             out_free;

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= phrf_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign out_free  = !res_valid_reg || !res_stall;
    assign req_stall = (state_reg != phrf_pkg::S_IDLE);
    assign res_valid = res_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        res_valid_next = res_valid_reg && res_stall;
        case (state_reg)
            phrf_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.start_scan ? phrf_pkg::S_SCAN : phrf_pkg::S_DONE;
                end
            end
            phrf_pkg::S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.scan_hit || stat.scan_end)
                begin
                    cmd.scan_done = 1'b1;
                    state_next    = phrf_pkg::S_DONE;
                end
            end
            phrf_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = phrf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = phrf_pkg::S_IDLE;
            end
        endcase
    end

    // Checks
    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over an unread result");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg != phrf_pkg::S_IDLE))
        else $error("controller stayed idle after a request");

    a_scan_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == phrf_pkg::S_SCAN) && (stat.scan_hit || stat.scan_end)
        |=> (state_reg == phrf_pkg::S_DONE))
        else $error("scan outcome not handed on");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> res_valid_reg)
        else $error("loaded result not presented");

endmodule

/* rtl/core/phrf_dp.sv */
// Datapath: rule table memory, rule count, header register, scan pipeline and result registers.
`timescale 1ns / 1ps

module phrf_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  phrf_pkg::cmd_t   cmd,
    output phrf_pkg::stat_t  stat,
    input  logic [1:0]       kind,
    input  logic [7:0]       test_flags,
    input  logic [15:0]      net_proto,
    input  logic [7:0]       trans_proto,
    input  logic [15:0]      src_port,
    input  logic [15:0]      dst_port,
    input  logic [31:0]      src_addr,
    input  logic [31:0]      dst_addr,
    input  logic [31:0]      src_mask,
    input  logic [31:0]      dst_mask,
    output logic             matched,
    output logic [1:0]       status
);

    phrf_pkg::rule_t                 rule_mem [phrf_pkg::MAX_RULES];
    logic [phrf_pkg::CNT_W-1:0]      rule_count_reg;
    logic [phrf_pkg::CNT_W-1:0]      rule_count_next;
    logic [phrf_pkg::CNT_W-1:0]      issue_cnt_reg;
    logic [phrf_pkg::CNT_W-1:0]      issue_cnt_next;
    logic                            rd_vld_reg;
    logic                            rd_vld_next;
    logic                            rd_last_reg;
    logic                            rd_last_next;
    phrf_pkg::rule_t                 rd_data_reg;
    phrf_pkg::hdr_t                  hdr_reg;
    logic                            pend_matched_reg;
    logic [1:0]                      pend_status_reg;
    logic                            out_matched_reg;
    logic [1:0]                      out_status_reg;

    logic                            table_full;
    logic                            mem_we;
    logic                            issue;
    logic                            hit;
    logic                            acc_matched;
    logic [1:0]                      acc_status;
    phrf_pkg::rule_t                 wr_rule;
    phrf_pkg::hdr_t                  hdr_in;

    assign table_full = (rule_count_reg >= phrf_pkg::CNT_W'(phrf_pkg::MAX_RULES));

    assign wr_rule = '{tests: test_flags, net_proto: net_proto, trans_proto: trans_proto,
                       src_port: src_port, dst_port: dst_port, src_addr: src_addr,
                       src_mask: src_mask, dst_addr: dst_addr, dst_mask: dst_mask};

    assign hdr_in = '{net_proto: net_proto, trans_proto: trans_proto, src_port: src_port,
                      dst_port: dst_port, src_addr: src_addr, dst_addr: dst_addr};

    // Immediate effects of an accepted request
    always_comb
    begin
        mem_we          = 1'b0;
        acc_matched     = 1'b0;
        acc_status      = phrf_pkg::ST_OK;
        rule_count_next = rule_count_reg;
        if (cmd.accept)
        begin
            case (kind)
                phrf_pkg::KIND_ADD:
                begin
                    if (test_flags == 8'd0)
                        acc_status = phrf_pkg::ST_NO_TESTS;
                    else if (table_full)
                        acc_status = phrf_pkg::ST_FULL;
                    else
                    begin
                        mem_we          = 1'b1;
                        rule_count_next = rule_count_reg + phrf_pkg::CNT_W'(1);
                    end
                end
                phrf_pkg::KIND_MATCH:
                begin
                    // empty table lets everything through
                    acc_matched = (rule_count_reg == '0);
                end
                phrf_pkg::KIND_CLEAR:
                begin
                    rule_count_next = '0;
                end
                default:
                begin
                    acc_matched = 1'b0;
                end
            endcase
        end
    end

    assign stat.start_scan = (kind == phrf_pkg::KIND_MATCH) && (rule_count_reg != '0);

    // Scan: one rule read per cycle, compared in the cycle after its read
    assign issue          = cmd.scan_en && (issue_cnt_reg < rule_count_reg);
    assign issue_cnt_next = cmd.accept ? '0
                          : (issue ? issue_cnt_reg + phrf_pkg::CNT_W'(1) : issue_cnt_reg);
    assign rd_vld_next    = issue;
    assign rd_last_next   = (issue_cnt_reg + phrf_pkg::CNT_W'(1)) == rule_count_reg;

    assign hit           = phrf_pkg::rule_hits(rd_data_reg, hdr_reg);
    assign stat.scan_hit = rd_vld_reg && hit;
    assign stat.scan_end = rd_vld_reg && rd_last_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
            issue_cnt_reg  <= '0;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
        end
        else
        begin
            rule_count_reg <= rule_count_next;
            issue_cnt_reg  <= issue_cnt_next;
            rd_vld_reg     <= rd_vld_next;
            rd_last_reg    <= rd_last_next;
        end
    end

    // Rule table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            rule_mem[rule_count_reg[phrf_pkg::IDX_W-1:0]] <= wr_rule;
        if (issue)
            rd_data_reg <= rule_mem[issue_cnt_reg[phrf_pkg::IDX_W-1:0]];
    end

    // Header and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hdr_reg          <= hdr_in;
            pend_matched_reg <= acc_matched;
            pend_status_reg  <= acc_status;
        end
        else if (cmd.scan_done)
        begin
            pend_matched_reg <= stat.scan_hit;
            pend_status_reg  <= phrf_pkg::ST_OK;
        end
        if (cmd.out_load)
        begin
            out_matched_reg <= pend_matched_reg;
            out_status_reg  <= pend_status_reg;
        end
    end

    assign matched = out_matched_reg;
    assign status  = out_status_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rule_count_reg <= phrf_pkg::CNT_W'(phrf_pkg::MAX_RULES))
        else $error("rule count beyond table size");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !table_full)
        else $error("rule written into a full table");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (issue_cnt_reg < rule_count_reg))
        else $error("scan read beyond stored rules");

endmodule

/* rtl/core/packet_header_rule_filter_unit.sv */
// Top level of the packet header rule filter: controller plus datapath.
`timescale 1ns / 1ps
// Use:
//   Request channel (req_valid / req_stall) carries kind plus rule or header fields.
//   kind add stores a rule, kind clear empties the table, kind match tests a header.
//   Result channel (res_valid / res_stall) returns matched and status, one per request.
//   A request is taken when req_valid is high and req_stall is low.
// Sequencing:
//   Add, clear and match on an empty table: accepted in idle, the controller goes
//   to the done state, loads the result into the output register and raises res_valid.
//   Match: the scan reads one stored rule per cycle from the rule memory and
//   compares it in the cycle after its read, stopping at the first hit or the
//   last stored rule; the result then goes through the done state as above.
//   One request is in work at a time: req_stall stays high until its result is loaded.
// Reset:
//   rst_n clears the rule count (empty table) and the output valid; rule
//   memory contents are left as they are and are never read unless written.
// Back-pressure:
//   The result sits in an output register while res_stall is high; the next
//   request may be taken and worked on, and waits to load until that result is taken.

module packet_header_rule_filter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  test_flags,
    input  logic [15:0] net_proto,
    input  logic [7:0]  trans_proto,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [31:0] src_mask,
    input  logic [31:0] dst_mask,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        matched,
    output logic [1:0]  status
);

    phrf_pkg::cmd_t  cmd;
    phrf_pkg::stat_t stat;

    // Sequencing
    phrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Rule table and compare
    phrf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .test_flags  (test_flags),
        .net_proto   (net_proto),
        .trans_proto (trans_proto),
        .src_port    (src_port),
        .dst_port    (dst_port),
        .src_addr    (src_addr),
        .dst_addr    (dst_addr),
        .src_mask    (src_mask),
        .dst_mask    (dst_mask),
        .matched     (matched),
        .status      (status)
    );

endmodule

/* sim/packet_header_rule_filter_unit_tb.sv */
// Self-checking testbench for the packet header rule filter unit.
`timescale 1ns / 1ps

module packet_header_rule_filter_unit_tb;

    localparam int unsigned ITEM_TARGET = 1550;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned LONG_HOLD   = 400;

    // Spare request kind: the block answers it but changes nothing
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic [31:0] ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] ZERO = 32'h0000_0000;

    // One request as presented on the input channel
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  flags;
        logic [15:0] net_proto;
        logic [7:0]  trans_proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] src_mask;
        logic [31:0] dst_mask;
    } filter_req_t;

    // One result as returned on the output channel
    typedef struct packed {
        logic              matched;
        phrf_pkg::status_t status;
    } verdict_t;

    // Directed stimulus row; want is used only where fixed is set
    typedef struct packed {
        filter_req_t req;
        logic [7:0]  reps;
        logic        fixed;
        verdict_t    want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  kind;
    logic [7:0]  test_flags;
    logic [15:0] net_proto;
    logic [7:0]  trans_proto;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] src_mask;
    logic [31:0] dst_mask;
    logic        res_valid;
    logic        res_stall;
    logic        matched;
    logic [1:0]  status;

    // Shadow rule table
    phrf_pkg::rule_t stored_rule [phrf_pkg::MAX_RULES];
    int unsigned     stored_count;

    // Expected verdicts, oldest first
    verdict_t    verdict_q [$];

    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned sent_count;
    int unsigned results_seen;
    int unsigned req_burst_left;
    int unsigned res_burst_left;
    int unsigned long_hold_cycles;

    int unsigned n_added;
    int unsigned n_rejected;
    int unsigned n_full;
    int unsigned n_matches;
    int unsigned n_passed;
    int unsigned n_clears;

    packet_header_rule_filter_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .kind        (kind),
        .test_flags  (test_flags),
        .net_proto   (net_proto),
        .trans_proto (trans_proto),
        .src_port    (src_port),
        .dst_port    (dst_port),
        .src_addr    (src_addr),
        .dst_addr    (dst_addr),
        .src_mask    (src_mask),
        .dst_mask    (dst_mask),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .matched     (matched),
        .status      (status)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Mismatch reporting
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Does one stored rule accept the header
    function automatic logic rule_accepts(input phrf_pkg::rule_t r, input filter_req_t h);
        logic [31:0] src_by_smask;
        logic [31:0] dst_by_smask;
        logic [31:0] dst_by_dmask;
        src_by_smask = h.src_addr & r.src_mask;
        dst_by_smask = h.dst_addr & r.src_mask;
        dst_by_dmask = h.dst_addr & r.dst_mask;
        return !((r.tests[phrf_pkg::T_NET]   && r.net_proto   != h.net_proto)
              || (r.tests[phrf_pkg::T_TRANS] && r.trans_proto != h.trans_proto)
              || (r.tests[phrf_pkg::T_EPORT] && r.src_port != h.src_port
                                             && r.src_port != h.dst_port)
              || (r.tests[phrf_pkg::T_DPORT] && r.dst_port != h.dst_port)
              || (r.tests[phrf_pkg::T_SPORT] && r.src_port != h.src_port)
              || (r.tests[phrf_pkg::T_EADDR] && r.src_addr != src_by_smask
                                             && r.src_addr != dst_by_smask)
              || (r.tests[phrf_pkg::T_SADDR] && r.src_addr != src_by_smask)
              || (r.tests[phrf_pkg::T_DADDR] && r.dst_addr != dst_by_dmask));
    endfunction

    // Apply one request to the shadow table and return its verdict
    function automatic verdict_t apply_request(input filter_req_t q);
        verdict_t        v;
        phrf_pkg::rule_t nr;
        int              i;
        v.matched = 1'b0;
        v.status  = phrf_pkg::ST_OK;
        case (q.kind)
            phrf_pkg::KIND_ADD:
            begin
                if (q.flags == 8'd0)
                begin
                    v.status = phrf_pkg::ST_NO_TESTS;
                    n_rejected++;
                end
                else if (stored_count >= phrf_pkg::MAX_RULES)
                begin
                    v.status = phrf_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    nr.tests       = q.flags;
                    nr.net_proto   = q.net_proto;
                    nr.trans_proto = q.trans_proto;
                    nr.src_port    = q.src_port;
                    nr.dst_port    = q.dst_port;
                    nr.src_addr    = q.src_addr;
                    nr.src_mask    = q.src_mask;
                    nr.dst_addr    = q.dst_addr;
                    nr.dst_mask    = q.dst_mask;
                    stored_rule[stored_count] = nr;
                    stored_count++;
                    n_added++;
                end
            end
            phrf_pkg::KIND_MATCH:
            begin
                // empty table lets everything through
                v.matched = (stored_count == 0);
                for (i = 0; i < stored_count; i++)
                begin
                    if (rule_accepts(stored_rule[i], q))
                        v.matched = 1'b1;
                end
                n_matches++;
                if (v.matched)
                    n_passed++;
            end
            phrf_pkg::KIND_CLEAR:
            begin
                stored_count = 0;
                n_clears++;
            end
            default:
            begin
            end
        endcase
        return v;
    endfunction

    // Present one request, wait for it to be taken, then log its verdict
    task automatic send_request(input filter_req_t q, input logic fixed, input verdict_t want);
        int unsigned gap;
        verdict_t    v;
        if (req_burst_left > 0)
        begin
            gap = 0;
            req_burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 39) == 0)
                req_burst_left = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        kind        <= q.kind;
        test_flags  <= q.flags;
        net_proto   <= q.net_proto;
        trans_proto <= q.trans_proto;
        src_port    <= q.src_port;
        dst_port    <= q.dst_port;
        src_addr    <= q.src_addr;
        dst_addr    <= q.dst_addr;
        src_mask    <= q.src_mask;
        dst_mask    <= q.dst_mask;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        v = apply_request(q);
        if (fixed)
            v = want;
        verdict_q.push_back(v);
        sent_count++;
    endtask

    // Hold the request line low until every verdict has come back
    task automatic drain_results();
        req_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic plan_row_t plan_row(input logic [1:0] k, input logic [7:0] f,
                                           input logic [31:0] fill, input logic [7:0] reps,
                                           input logic fixed, input logic m,
                                           input phrf_pkg::status_t s);
        plan_row_t p;
        p.req.kind        = k;
        p.req.flags       = f;
        p.req.net_proto   = fill[15:0];
        p.req.trans_proto = fill[7:0];
        p.req.src_port    = fill[15:0];
        p.req.dst_port    = fill[15:0];
        p.req.src_addr    = fill;
        p.req.dst_addr    = fill;
        p.req.src_mask    = fill;
        p.req.dst_mask    = fill;
        p.reps            = reps;
        p.fixed           = fixed;
        p.want.matched    = m;
        p.want.status     = s;
        return p;
    endfunction

    function automatic logic [31:0] prefix_mask(input int unsigned len);
        return (len == 0) ? ZERO : (ONES << (32 - len));
    endfunction

    // Fully random request, any kind
    function automatic filter_req_t rand_noise();
        filter_req_t q;
        q.kind        = 2'($urandom_range(0, 3));
        q.flags       = 8'($urandom);
        q.net_proto   = 16'($urandom);
        q.trans_proto = 8'($urandom);
        q.src_port    = 16'($urandom);
        q.dst_port    = 16'($urandom);
        q.src_addr    = $urandom;
        q.dst_addr    = $urandom;
        q.src_mask    = $urandom;
        q.dst_mask    = $urandom;
        return q;
    endfunction

    // Plausible rule: few tests, mostly prefix masks, addresses within the mask
    function automatic filter_req_t rand_rule();
        filter_req_t q;
        int unsigned n;
        q       = rand_noise();
        q.kind  = phrf_pkg::KIND_ADD;
        q.flags = 8'd0;
        n       = $urandom_range(1, 3);
        repeat (n) q.flags[$urandom_range(0, 7)] = 1'b1;
        if ($urandom_range(0, 9) == 0)
            q.flags = 8'($urandom);
        if ($urandom_range(0, 1) == 0)
            q.net_proto = 16'h0800;
        if ($urandom_range(0, 4) != 0)
            q.src_mask = prefix_mask($urandom_range(0, 32));
        if ($urandom_range(0, 4) != 0)
            q.dst_mask = prefix_mask($urandom_range(0, 32));
        if ($urandom_range(0, 7) != 0)
            q.src_addr = q.src_addr & q.src_mask;
        if ($urandom_range(0, 7) != 0)
            q.dst_addr = q.dst_addr & q.dst_mask;
        return q;
    endfunction

    // Header built to hit a given rule, sometimes crossed or nudged off it
    function automatic filter_req_t probe_for(input filter_req_t r);
        filter_req_t h;
        h          = r;
        h.kind     = phrf_pkg::KIND_MATCH;
        h.flags    = 8'($urandom);
        h.src_mask = $urandom;
        h.dst_mask = $urandom;
        h.src_addr = r.src_addr | ($urandom & ~r.src_mask);
        h.dst_addr = r.dst_addr | ($urandom & ~r.dst_mask);
        // crossed: rule port and address show up on the destination side
        if ($urandom_range(0, 3) == 0)
        begin
            h.src_port = 16'($urandom);
            h.dst_port = r.src_port;
            h.src_addr = $urandom;
            h.dst_addr = r.src_addr | ($urandom & ~r.src_mask);
        end
        case ($urandom_range(0, 7))
            0: h.net_proto   = h.net_proto ^ (16'd1 << $urandom_range(0, 15));
            1: h.trans_proto = h.trans_proto ^ (8'd1 << $urandom_range(0, 7));
            2: h.src_port    = h.src_port ^ (16'd1 << $urandom_range(0, 15));
            3: h.dst_port    = h.dst_port ^ (16'd1 << $urandom_range(0, 15));
            4: h.src_addr    = h.src_addr ^ (32'd1 << $urandom_range(0, 31));
            5: h.dst_addr    = h.dst_addr ^ (32'd1 << $urandom_range(0, 31));
            default:
            begin
            end
        endcase
        return h;
    endfunction

    // Random traffic: mostly clear / add rules / probe sequences, some noise
    task automatic run_random(input int unsigned target);
        filter_req_t made [$];
        filter_req_t q;
        int unsigned n;
        int unsigned i;
        while (sent_count < target)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                made.delete();
                if ($urandom_range(0, 9) < 7)
                begin
                    q      = rand_noise();
                    q.kind = phrf_pkg::KIND_CLEAR;
                    send_request(q, 1'b0, '0);
                    if ($urandom_range(0, 7) == 0)
                    begin
                        q      = rand_noise();
                        q.kind = phrf_pkg::KIND_MATCH;
                        send_request(q, 1'b0, '0);
                    end
                end
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 18)
                                                : $urandom_range(1, 5);
                for (i = 0; i < n; i++)
                begin
                    q = rand_rule();
                    made.push_back(q);
                    send_request(q, 1'b0, '0);
                end
                n = $urandom_range(2, 8);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 4) != 0)
                        q = probe_for(made[$urandom_range(0, made.size() - 1)]);
                    else
                    begin
                        q      = rand_noise();
                        q.kind = phrf_pkg::KIND_MATCH;
                    end
                    send_request(q, 1'b0, '0);
                end
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_request(rand_noise(), 1'b0, '0);
            end
        end
    endtask

    // Result side: random stalls, one long hold-off on request, checks each result
    initial
    begin : result_side
        int unsigned hold;
        verdict_t    v;
        res_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_cycles > 0)
            begin
                hold             = long_hold_cycles;
                long_hold_cycles = 0;
            end
            else if (res_burst_left > 0)
            begin
                hold = 0;
                res_burst_left--;
            end
            else
            begin
                hold = $urandom_range(0, 7);
                if ($urandom_range(0, 39) == 0)
                    res_burst_left = $urandom_range(10, 40);
            end
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
            results_seen++;
            if (verdict_q.size() == 0)
                report_mismatch($sformatf("result with none pending (matched %0d status %0d)",
                                          matched, status));
            else
            begin
                v = verdict_q.pop_front();
                if (matched !== v.matched)
                    report_mismatch($sformatf("matched got %0d expected %0d",
                                              matched, v.matched));
                if (status !== v.status)
                    report_mismatch($sformatf("status got %0d expected %0d (%s)",
                                              status, v.status, v.status.name()));
            end
        end
    end

    // Request side: reset, directed table, random phases, end of run
    initial
    begin : request_side
        plan_row_t   plan [$];
        int unsigned r;
        int unsigned k;
        int          b;

        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        kind        <= phrf_pkg::KIND_ADD;
        test_flags  <= 8'd0;
        net_proto   <= 16'd0;
        trans_proto <= 8'd0;
        src_port    <= 16'd0;
        dst_port    <= 16'd0;
        src_addr    <= ZERO;
        dst_addr    <= ZERO;
        src_mask    <= ZERO;
        dst_mask    <= ZERO;
        stored_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // header against an empty table passes; rule without tests; spare kind
        plan.push_back(plan_row(phrf_pkg::KIND_MATCH, 8'h00, ONES, 8'd1,
                                1'b1, 1'b1, phrf_pkg::ST_OK));
        plan.push_back(plan_row(phrf_pkg::KIND_ADD, 8'h00, ONES, 8'd1,
                                1'b1, 1'b0, phrf_pkg::ST_NO_TESTS));
        plan.push_back(plan_row(KIND_SPARE, 8'hFF, ONES, 8'd1,
                                1'b1, 1'b0, phrf_pkg::ST_OK));
        // one rule per test, alternating all-ones and all-zero fields
        for (b = 0; b < 8; b++)
            plan.push_back(plan_row(phrf_pkg::KIND_ADD, 8'd1 << b,
                                    (b % 2 == 0) ? ONES : ZERO,
                                    8'd1, 1'b1, 1'b0, phrf_pkg::ST_OK));
        plan.push_back(plan_row(phrf_pkg::KIND_MATCH, 8'h00, ZERO, 8'd1,
                                1'b0, 1'b0, phrf_pkg::ST_OK));
        plan.push_back(plan_row(phrf_pkg::KIND_MATCH, 8'hFF, ONES, 8'd1,
                                1'b0, 1'b0, phrf_pkg::ST_OK));
        // fill the table to the brim, then overflow it
        plan.push_back(plan_row(phrf_pkg::KIND_ADD, 8'hFF, ONES, 8'd1,
                                1'b1, 1'b0, phrf_pkg::ST_OK));
        plan.push_back(plan_row(phrf_pkg::KIND_ADD, 8'hFF, ZERO, 8'd7,
                                1'b1, 1'b0, phrf_pkg::ST_OK));
        plan.push_back(plan_row(phrf_pkg::KIND_ADD, 8'h01, ONES, 8'd1,
                                1'b1, 1'b0, phrf_pkg::ST_FULL));
        plan.push_back(plan_row(phrf_pkg::KIND_ADD, 8'h00, ZERO, 8'd1,
                                1'b1, 1'b0, phrf_pkg::ST_NO_TESTS));
        plan.push_back(plan_row(phrf_pkg::KIND_MATCH, 8'h00, ONES, 8'd1,
                                1'b0, 1'b0, phrf_pkg::ST_OK));
        plan.push_back(plan_row(phrf_pkg::KIND_MATCH, 8'hFF, ZERO, 8'd1,
                                1'b0, 1'b0, phrf_pkg::ST_OK));
        // clear, then the empty table passes again
        plan.push_back(plan_row(phrf_pkg::KIND_CLEAR, 8'hFF, ONES, 8'd1,
                                1'b1, 1'b0, phrf_pkg::ST_OK));
        plan.push_back(plan_row(phrf_pkg::KIND_MATCH, 8'h00, ZERO, 8'd1,
                                1'b1, 1'b1, phrf_pkg::ST_OK));

        for (r = 0; r < plan.size(); r++)
            for (k = 0; k < plan[r].reps; k++)
                send_request(plan[r].req, plan[r].fixed, plan[r].want);

        // sender pause until everything has come back
        drain_results();

        run_random(ITEM_TARGET / 2);

        // receiver holds off while requests keep coming
        long_hold_cycles = LONG_HOLD;
        req_burst_left   = 80;
        run_random((ITEM_TARGET * 3) / 4);

        drain_results();
        run_random(ITEM_TARGET);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d requests, %0d results; rules stored %0d, no-test rejects %0d, full %0d",
                 sent_count, results_seen, n_added, n_rejected, n_full);
        $display("tb: header lookups %0d (%0d passed), table clears %0d, mismatches %0d",
                 n_matches, n_passed, n_clears, error_count);
        if (error_count == 0 && verdict_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
